@@ hw/rtl/fbba_pkg.sv @@
// Shared types, constants and helpers for the free block bitmap allocator.
`timescale 1ns / 1ps

package fbba_pkg;

  // Bitmap geometry
  localparam int MAP_BYTES = 4096;
  localparam int ADDR_W    = $clog2(MAP_BYTES);
  localparam int LIM_W     = 13;
  localparam int BLK_W     = 15;
  localparam int TYPE_W    = 3;

  localparam logic [LIM_W-1:0] MAP_BYTES_L = LIM_W'(MAP_BYTES);

  // Request codes
  localparam logic [TYPE_W-1:0] REQ_FIND  = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_SET   = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_CLEAR = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_WRITE = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_READ  = 3'd4;

  localparam logic [7:0] BYTE_FULL = 8'hFF;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_RMW,
    ST_READ,
    ST_RESP
  } state_t;

  // One bitmap memory access
  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  // Position of the lowest clear bit of a byte (byte must not be all ones)
  function automatic logic [2:0] first_zero(input logic [7:0] b);
    logic [2:0] pos;
    pos = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (!b[k]) begin
        pos = 3'(k);
      end
    end
    return pos;
  endfunction

endpackage

@@ hw/rtl/fbba_if.sv @@
// Request and response channel interfaces of the bitmap allocator.
`timescale 1ns / 1ps

interface fbba_req_if;
  logic                       valid;
  logic                       ready;
  logic [fbba_pkg::TYPE_W-1:0] req_type;
  logic [fbba_pkg::BLK_W-1:0]  block_number;
  logic [fbba_pkg::ADDR_W-1:0] byte_index;
  logic [7:0]                 byte_value;

  modport source (output valid, req_type, block_number, byte_index, byte_value,
                  input ready);
  modport sink   (input valid, req_type, block_number, byte_index, byte_value,
                  output ready);
endinterface

interface fbba_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [fbba_pkg::BLK_W-1:0] free_block;
  logic [7:0]                 read_value;
  logic                       status;

  modport source (output valid, found, free_block, read_value, status, input ready);
  modport sink   (input valid, found, free_block, read_value, status, output ready);
endinterface

@@ hw/rtl/fbba_bitmap_ram.sv @@
// Single-port bitmap byte store with registered read data.
`timescale 1ns / 1ps

module fbba_bitmap_ram (
  input  logic               clk,
  input  fbba_pkg::mem_req_t req,
  output logic [7:0]         rdata
);

  logic [7:0] mem [fbba_pkg::MAP_BYTES];
  logic [7:0] rdata_r;

  // One access per cycle: write, or read with registered read data
  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rdata_r <= mem[req.addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/fbba_ctrl.sv @@
// Request sequencer: byte scan for find, read-modify-write, byte access, response.
`timescale 1ns / 1ps

module fbba_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [fbba_pkg::LIM_W-1:0]  cfg_wdata,
  fbba_req_if.sink                    in_req,
  fbba_rsp_if.source                  out_rsp,
  output fbba_pkg::mem_req_t          mem_req,
  input  logic [7:0]                  mem_rdata
);

  fbba_pkg::state_t state_r, state_nxt;

  logic [fbba_pkg::LIM_W-1:0]  bytes_r, bytes_nxt;
  logic [fbba_pkg::TYPE_W-1:0] req_r, req_nxt;
  logic [fbba_pkg::BLK_W-1:0]  blk_r, blk_nxt;
  logic [fbba_pkg::LIM_W-1:0]  scan_r, scan_nxt;
  logic                        pend_r, pend_nxt;
  logic [fbba_pkg::ADDR_W-1:0] pend_addr_r, pend_addr_nxt;
  logic                        found_r, found_nxt;
  logic [fbba_pkg::BLK_W-1:0]  free_r, free_nxt;
  logic [7:0]                  rdv_r, rdv_nxt;
  logic                        stat_r, stat_nxt;
  logic                        ovalid_r, ovalid_nxt;
  logic                        ofound_r, ofound_nxt;
  logic [fbba_pkg::BLK_W-1:0]  ofree_r, ofree_nxt;
  logic [7:0]                  ordv_r, ordv_nxt;
  logic                        ostat_r, ostat_nxt;

  logic [fbba_pkg::LIM_W-1:0]  lim;
  logic                        issue_ok;
  logic [7:0]                  bit_mask;

  // Effective byte count, capped at the store size
  assign lim      = (bytes_r > fbba_pkg::MAP_BYTES_L) ? fbba_pkg::MAP_BYTES_L : bytes_r;
  assign issue_ok = scan_r < lim;
  assign bit_mask = 8'd1 << blk_r[2:0];

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= fbba_pkg::ST_IDLE;
      bytes_r  <= fbba_pkg::MAP_BYTES_L;
      pend_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      bytes_r  <= bytes_nxt;
      pend_r   <= pend_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    blk_r       <= blk_nxt;
    scan_r      <= scan_nxt;
    pend_addr_r <= pend_addr_nxt;
    found_r     <= found_nxt;
    free_r      <= free_nxt;
    rdv_r       <= rdv_nxt;
    stat_r      <= stat_nxt;
    ofound_r    <= ofound_nxt;
    ofree_r     <= ofree_nxt;
    ordv_r      <= ordv_nxt;
    ostat_r     <= ostat_nxt;
  end

  // Next state and outputs
  always_comb begin
    state_nxt     = state_r;
    bytes_nxt     = cfg_we ? cfg_wdata : bytes_r;
    req_nxt       = req_r;
    blk_nxt       = blk_r;
    scan_nxt      = scan_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    found_nxt     = found_r;
    free_nxt      = free_r;
    rdv_nxt       = rdv_r;
    stat_nxt      = stat_r;
    ovalid_nxt    = ovalid_r;
    ofound_nxt    = ofound_r;
    ofree_nxt     = ofree_r;
    ordv_nxt      = ordv_r;
    ostat_nxt     = ostat_r;
    mem_req       = '0;
    in_req.ready  = 1'b0;

    // Output register drains independently
    if (ovalid_r && out_rsp.ready) begin
      ovalid_nxt = 1'b0;
    end

    case (state_r)
      fbba_pkg::ST_IDLE: begin
        in_req.ready = 1'b1;
        if (in_req.valid) begin
          req_nxt   = in_req.req_type;
          blk_nxt   = in_req.block_number;
          scan_nxt  = '0;
          pend_nxt  = 1'b0;
          found_nxt = 1'b0;
          free_nxt  = '0;
          rdv_nxt   = '0;
          stat_nxt  = 1'b0;
          state_nxt = fbba_pkg::ST_RESP;
          case (in_req.req_type)
            fbba_pkg::REQ_FIND: begin
              state_nxt = fbba_pkg::ST_FIND;
            end
            fbba_pkg::REQ_SET, fbba_pkg::REQ_CLEAR: begin
              if ({1'b0, in_req.block_number[fbba_pkg::BLK_W-1:3]} >= lim) begin
                stat_nxt = 1'b1;
              end else begin
                mem_req.en   = 1'b1;
                mem_req.addr = in_req.block_number[fbba_pkg::BLK_W-1:3];
                state_nxt    = fbba_pkg::ST_RMW;
              end
            end
            fbba_pkg::REQ_WRITE: begin
              if ({1'b0, in_req.byte_index} >= lim) begin
                stat_nxt = 1'b1;
              end else begin
                mem_req.en    = 1'b1;
                mem_req.we    = 1'b1;
                mem_req.addr  = in_req.byte_index;
                mem_req.wdata = in_req.byte_value;
              end
            end
            fbba_pkg::REQ_READ: begin
              if ({1'b0, in_req.byte_index} >= lim) begin
                stat_nxt = 1'b1;
              end else begin
                mem_req.en   = 1'b1;
                mem_req.addr = in_req.byte_index;
                state_nxt    = fbba_pkg::ST_READ;
              end
            end
            default: begin
              // unknown request: all-zero response
            end
          endcase
        end
      end

      // One byte read issued per cycle, previous byte checked in parallel
      fbba_pkg::ST_FIND: begin
        mem_req.en    = issue_ok;
        mem_req.addr  = scan_r[fbba_pkg::ADDR_W-1:0];
        pend_nxt      = issue_ok;
        pend_addr_nxt = scan_r[fbba_pkg::ADDR_W-1:0];
        scan_nxt      = scan_r + 1'b1;
        if (pend_r && (mem_rdata != fbba_pkg::BYTE_FULL)) begin
          found_nxt = 1'b1;
          free_nxt  = {pend_addr_r, fbba_pkg::first_zero(mem_rdata)};
          pend_nxt  = 1'b0;
          state_nxt = fbba_pkg::ST_RESP;
        end else if (!issue_ok) begin
          pend_nxt  = 1'b0;
          state_nxt = fbba_pkg::ST_RESP;
        end
      end

      // Write back the byte with one bit set or cleared
      fbba_pkg::ST_RMW: begin
        mem_req.en    = 1'b1;
        mem_req.we    = 1'b1;
        mem_req.addr  = blk_r[fbba_pkg::BLK_W-1:3];
        mem_req.wdata = (req_r == fbba_pkg::REQ_SET) ? (mem_rdata | bit_mask)
                                                     : (mem_rdata & ~bit_mask);
        state_nxt     = fbba_pkg::ST_RESP;
      end

      fbba_pkg::ST_READ: begin
        rdv_nxt   = mem_rdata;
        state_nxt = fbba_pkg::ST_RESP;
      end

      // Hand the result to the output register once it is free
      fbba_pkg::ST_RESP: begin
        if (!ovalid_r || out_rsp.ready) begin
          ovalid_nxt = 1'b1;
          ofound_nxt = found_r;
          ofree_nxt  = free_r;
          ordv_nxt   = rdv_r;
          ostat_nxt  = stat_r;
          state_nxt  = fbba_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = fbba_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_rsp.valid      = ovalid_r;
  assign out_rsp.found      = ofound_r;
  assign out_rsp.free_block = ofree_r;
  assign out_rsp.read_value = ordv_r;
  assign out_rsp.status     = ostat_r;

endmodule

@@ hw/rtl/free_block_bitmap_allocator_core.sv @@
// Top level of the free block bitmap allocator.
//
// Usage:
//   in_req  carries one request per transfer: find first free block, set or
//           clear one block bit, write or read one bitmap byte.
//   out_rsp carries exactly one response per request, in request order.
//   cfg_we/cfg_wdata write bytes_in_use; write it only while no request is
//   outstanding. Values above 4096 act as 4096, zero means an empty map.
// Timing:
//   in_req.ready is high only while the sequencer is idle.
//   Find scans one byte per cycle through the single memory port, up to the
//   first byte with a clear bit (through all bytes in use when none is free).
//   Set/clear read the byte, then modify it and write it back; read byte
//   reads the byte, then captures it; write byte, out-of-range and unknown
//   requests go straight to the response.
// Reset (synchronous, rst_n low): sequencer idle, no response pending,
//   bytes_in_use = 4096. The bitmap is not cleared and must be loaded first.
// Stall: a response waits in the output register while out_rsp.ready is low;
//   one further request is still accepted and processed, then held.
`timescale 1ns / 1ps

module free_block_bitmap_allocator_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [fbba_pkg::LIM_W-1:0] cfg_wdata,
  fbba_req_if.sink                   in_req,
  fbba_rsp_if.source                 out_rsp
);

  fbba_pkg::mem_req_t mem_req;
  logic [7:0]         mem_rdata;

  fbba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_req),
    .out_rsp   (out_rsp),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  fbba_bitmap_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

@@ hw/rtl/fbba_checker.sv @@
// Port-level checks of the bitmap allocator, bound to the top level.
`timescale 1ns / 1ps

module fbba_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_found,
  input logic [fbba_pkg::BLK_W-1:0] out_free_block,
  input logic [7:0]                 out_read_value,
  input logic                       out_status
);

  // One request at a time: ready drops after each accepted transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in progress");

  // Stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_free_block)
                                   && $stable(out_status)))
    else $error("stalled response changed");

  // Out-of-range status carries no other result
  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |->
      (!out_found && out_free_block == '0 && out_read_value == '0))
    else $error("out-of-range response carries data");

  // A found block and a read byte never come together
  a_found_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_read_value == '0))
    else $error("find response carries read data");

  // No block number without a hit
  a_free_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_free_block == '0))
    else $error("free block reported without a hit");

endmodule

bind free_block_bitmap_allocator_core fbba_checker u_fbba_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_req.valid),
  .in_ready       (in_req.ready),
  .out_valid      (out_rsp.valid),
  .out_ready      (out_rsp.ready),
  .out_found      (out_rsp.found),
  .out_free_block (out_rsp.free_block),
  .out_read_value (out_rsp.read_value),
  .out_status     (out_rsp.status)
);

@@ bench/tb.sv @@
// Self-checking testbench for the free block bitmap allocator core.
`timescale 1ns / 1ps

module tb;

  localparam int     BITS_PER_BYTE = 8;
  localparam longint RUN_LIMIT_NS  = 200_000_000;
  localparam int     RANDOM_PHASES = 10;
  localparam int     PHASE_ITEMS   = 93;
  localparam int     LOAD_BYTES    = 256;
  localparam int     SETTLE_CYCLES = 8;
  localparam int     TAIL_CYCLES   = 40;

  // Request codes the block does not know
  localparam logic [fbba_pkg::TYPE_W-1:0] REQ_UNUSED_FIRST = fbba_pkg::REQ_READ + 1'b1;
  localparam logic [fbba_pkg::TYPE_W-1:0] REQ_UNUSED_LAST  = '1;

  typedef struct packed {
    logic [fbba_pkg::TYPE_W-1:0] kind;
    logic [fbba_pkg::BLK_W-1:0]  blk;
    logic [fbba_pkg::ADDR_W-1:0] idx;
    logic [7:0]                  val;
  } alloc_req_t;

  typedef struct packed {
    logic                       found;
    logic [fbba_pkg::BLK_W-1:0] free_blk;
    logic [7:0]                 rd_val;
    logic                       status;
  } alloc_rsp_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [fbba_pkg::LIM_W-1:0] cfg_wdata;

  fbba_req_if req_ch ();
  fbba_rsp_if rsp_ch ();

  free_block_bitmap_allocator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (req_ch),
    .out_rsp   (rsp_ch)
  );

  always #5 clk = ~clk;

  // Shadow of the block state
  logic [7:0]                 bitmap_shadow [fbba_pkg::MAP_BYTES];
  bit                         written_shadow [fbba_pkg::MAP_BYTES];
  logic [fbba_pkg::LIM_W-1:0] lim_shadow;
  alloc_rsp_t                 expected_rsps [$];
  int unsigned                error_count;
  bit                         idle_on;
  int unsigned                hold_cycles;

  // Bytes that actually take part, with out-of-range limits folded
  function automatic int unsigned active_span();
    return (lim_shadow > fbba_pkg::MAP_BYTES) ? fbba_pkg::MAP_BYTES : lim_shadow;
  endfunction

  // Expected response for one request; updates the bitmap shadow
  function automatic alloc_rsp_t predict_alloc_rsp(alloc_req_t r);
    alloc_rsp_t  rsp;
    int unsigned span;
    int unsigned byte_no;
    logic [7:0]  bit_mask;
    rsp      = '0;
    span     = active_span();
    byte_no  = r.blk / BITS_PER_BYTE;
    bit_mask = 8'(1) << (r.blk % BITS_PER_BYTE);
    case (r.kind)
      fbba_pkg::REQ_FIND: begin
        for (int i = 0; i < span && !rsp.found; i++) begin
          for (int k = 0; k < BITS_PER_BYTE && !rsp.found; k++) begin
            if (!bitmap_shadow[i][k]) begin
              rsp.found    = 1'b1;
              rsp.free_blk = fbba_pkg::BLK_W'(i * BITS_PER_BYTE + k);
            end
          end
        end
      end
      fbba_pkg::REQ_SET, fbba_pkg::REQ_CLEAR: begin
        if (byte_no >= span) begin
          rsp.status = 1'b1;
        end else if (r.kind == fbba_pkg::REQ_SET) begin
          bitmap_shadow[byte_no] = bitmap_shadow[byte_no] | bit_mask;
        end else begin
          bitmap_shadow[byte_no] = bitmap_shadow[byte_no] & ~bit_mask;
        end
      end
      fbba_pkg::REQ_WRITE, fbba_pkg::REQ_READ: begin
        if (r.idx >= span) begin
          rsp.status = 1'b1;
        end else if (r.kind == fbba_pkg::REQ_WRITE) begin
          bitmap_shadow[r.idx]  = r.val;
          written_shadow[r.idx] = 1'b1;
        end else begin
          rsp.rd_val = bitmap_shadow[r.idx];
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  // First never-written byte a request would read, or -1
  function automatic int unwritten_byte(alloc_req_t r);
    int unsigned span;
    int unsigned byte_no;
    span    = active_span();
    byte_no = r.blk / BITS_PER_BYTE;
    case (r.kind)
      fbba_pkg::REQ_FIND: begin
        for (int i = 0; i < span; i++) begin
          if (!written_shadow[i]) return i;
          if (bitmap_shadow[i] != fbba_pkg::BYTE_FULL) return -1;
        end
      end
      fbba_pkg::REQ_SET, fbba_pkg::REQ_CLEAR: begin
        if (byte_no < span && !written_shadow[byte_no]) return int'(byte_no);
      end
      fbba_pkg::REQ_READ: begin
        if (r.idx < span && !written_shadow[r.idx]) return int'(r.idx);
      end
      default: ;
    endcase
    return -1;
  endfunction

  // A request that would read a never-written byte writes that byte instead
  function automatic alloc_req_t legalize_req(alloc_req_t r);
    int hole;
    hole = unwritten_byte(r);
    if (hole >= 0) begin
      r.kind = fbba_pkg::REQ_WRITE;
      r.idx  = fbba_pkg::ADDR_W'(hole);
    end
    return r;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!idle_on || roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic alloc_req_t make_req(logic [fbba_pkg::TYPE_W-1:0] kind,
                                          int unsigned blk, int unsigned idx,
                                          int unsigned val);
    alloc_req_t r;
    r.kind = kind;
    r.blk  = fbba_pkg::BLK_W'(blk);
    r.idx  = fbba_pkg::ADDR_W'(idx);
    r.val  = 8'(val);
    return r;
  endfunction

  // One transfer on the request channel; returns the predicted response
  task automatic send_req(input alloc_req_t r, output alloc_rsp_t want);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= r.kind;
    req_ch.block_number <= r.blk;
    req_ch.byte_index   <= r.idx;
    req_ch.byte_value   <= r.val;
    do @(posedge clk); while (!req_ch.ready);
    want = predict_alloc_rsp(r);
    expected_rsps.push_back(want);
  endtask

  task automatic send_only(input alloc_req_t r);
    alloc_rsp_t unused;
    send_req(r, unused);
  endtask

  // Stop offering and wait until every response is back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_bytes_in_use(input logic [fbba_pkg::LIM_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    lim_shadow = value;
  endtask

  // The low bytes are loaded first; no request ever reads an unwritten byte
  task automatic load_map();
    for (int i = 0; i < LOAD_BYTES; i++) begin
      send_only(make_req(fbba_pkg::REQ_WRITE, 0, i, fbba_pkg::BYTE_FULL));
    end
  endtask

  // Field extremes, every request kind, full map and top block
  task automatic test_directed_edges();
    // Top byte of the map at the full limit
    send_only(make_req(fbba_pkg::REQ_WRITE, 0, 4095, fbba_pkg::BYTE_FULL));
    send_only(make_req(fbba_pkg::REQ_CLEAR, 32767, 0, 0));
    send_only(make_req(fbba_pkg::REQ_READ, 0, 4095, 0));
    send_only(make_req(fbba_pkg::REQ_SET, 32767, 4095, 255));
    send_only(make_req(fbba_pkg::REQ_READ, 0, 4095, 0));
    // Find over the loaded bytes
    program_bytes_in_use(fbba_pkg::LIM_W'(LOAD_BYTES));
    send_only(make_req(fbba_pkg::REQ_FIND, 0, 0, 0));
    send_only(make_req(fbba_pkg::REQ_CLEAR, LOAD_BYTES * BITS_PER_BYTE - 1, 0, 0));
    send_only(make_req(fbba_pkg::REQ_FIND, 0, 0, 0));
    send_only(make_req(fbba_pkg::REQ_SET, LOAD_BYTES * BITS_PER_BYTE - 1, 0, 0));
    send_only(make_req(fbba_pkg::REQ_WRITE, 0, 0, 0));
    send_only(make_req(fbba_pkg::REQ_FIND, 32767, 4095, 255));
    send_only(make_req(fbba_pkg::REQ_READ, 0, 0, 0));
    send_only(make_req(fbba_pkg::REQ_SET, 0, 0, 0));
    send_only(make_req(fbba_pkg::REQ_FIND, 0, 0, 0));
    send_only(make_req(fbba_pkg::REQ_WRITE, 0, 0, fbba_pkg::BYTE_FULL));
    send_only(make_req(fbba_pkg::REQ_CLEAR, 9, 0, 0));
    send_only(make_req(fbba_pkg::REQ_FIND, 0, 0, 0));
    send_only(make_req(fbba_pkg::REQ_SET, 9, 0, 0));
    for (int c = REQ_UNUSED_FIRST; c <= REQ_UNUSED_LAST; c++) begin
      send_only(make_req(fbba_pkg::TYPE_W'(c), 32767, 4095, 255));
    end
  endtask

  // Limit of one byte, an empty map and a limit above the map size
  task automatic test_limit_edges();
    program_bytes_in_use(fbba_pkg::LIM_W'(1));
    send_only(make_req(fbba_pkg::REQ_SET, 8, 0, 0));
    send_only(make_req(fbba_pkg::REQ_WRITE, 0, 1, 0));
    send_only(make_req(fbba_pkg::REQ_READ, 0, 1, 0));
    send_only(make_req(fbba_pkg::REQ_CLEAR, 7, 0, 0));
    send_only(make_req(fbba_pkg::REQ_FIND, 0, 0, 0));
    send_only(make_req(fbba_pkg::REQ_SET, 7, 0, 0));
    send_only(make_req(fbba_pkg::REQ_FIND, 0, 0, 0));
    program_bytes_in_use(fbba_pkg::LIM_W'(0));
    send_only(make_req(fbba_pkg::REQ_FIND, 0, 0, 0));
    send_only(make_req(fbba_pkg::REQ_READ, 0, 0, 0));
    send_only(make_req(fbba_pkg::REQ_CLEAR, 0, 0, 0));
    program_bytes_in_use('1);
    send_only(make_req(fbba_pkg::REQ_READ, 0, 4095, 0));
    send_only(make_req(fbba_pkg::REQ_CLEAR, 32767, 0, 0));
  endtask

  // Random request, mostly aimed inside the loaded bytes in use
  function automatic alloc_req_t random_alloc_req(int unsigned span);
    alloc_req_t  r;
    int unsigned roll;
    int unsigned find_pct;
    int unsigned aim;
    r        = make_req(fbba_pkg::REQ_FIND, $urandom(), $urandom(), $urandom());
    roll     = $urandom_range(0, 99);
    find_pct = (span > 256) ? 3 : 18;
    aim      = (span > LOAD_BYTES) ? LOAD_BYTES : span;
    if (roll < 2) begin
      r.kind = fbba_pkg::TYPE_W'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
    end else if (roll >= 2 + find_pct) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: r.kind = fbba_pkg::REQ_SET;
        4, 5:       r.kind = fbba_pkg::REQ_CLEAR;
        6, 7:       r.kind = fbba_pkg::REQ_WRITE;
        default:    r.kind = fbba_pkg::REQ_READ;
      endcase
    end
    if (aim != 0 && $urandom_range(0, 99) < 85) begin
      r.blk = fbba_pkg::BLK_W'($urandom_range(0, aim * BITS_PER_BYTE - 1));
      r.idx = fbba_pkg::ADDR_W'($urandom_range(0, aim - 1));
    end
    if ($urandom_range(0, 1)) r.val = fbba_pkg::BYTE_FULL;
    return legalize_req(r);
  endfunction

  function automatic logic [fbba_pkg::LIM_W-1:0] phase_limit(int p);
    case (p)
      0:       return fbba_pkg::LIM_W'(16);
      1:       return fbba_pkg::LIM_W'(fbba_pkg::MAP_BYTES);
      2:       return fbba_pkg::LIM_W'(1);
      3:       return fbba_pkg::LIM_W'($urandom_range(2, 32));
      4:       return fbba_pkg::LIM_W'(0);
      5:       return fbba_pkg::LIM_W'($urandom_range(33, 512));
      6:       return '1;
      7:       return fbba_pkg::LIM_W'($urandom_range(fbba_pkg::MAP_BYTES + 1, 8190));
      8:       return fbba_pkg::LIM_W'($urandom_range(1, fbba_pkg::MAP_BYTES));
      default: return fbba_pkg::LIM_W'($urandom_range(1, 8));
    endcase
  endfunction

  // Allocate-on-find sequences with random traffic, over several limits
  task automatic test_random_traffic();
    alloc_req_t r;
    alloc_rsp_t want;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      program_bytes_in_use(phase_limit(p));
      idle_on = !(p == 3 || p == 7);
      want    = '0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (want.found && $urandom_range(0, 99) < 70) begin
          r = make_req(fbba_pkg::REQ_SET, want.free_blk, $urandom(), $urandom());
        end else begin
          r = random_alloc_req(active_span());
        end
        send_req(r, want);
        if (r.kind != fbba_pkg::REQ_FIND) want = '0;
      end
    end
    idle_on = 1'b1;
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_output_backpressure();
    program_bytes_in_use(fbba_pkg::LIM_W'(24));
    hold_cycles = 300;
    for (int n = 0; n < 16; n++) begin
      send_only(random_alloc_req(active_span()));
    end
  endtask

  // Response ready: random stalls plus a long hold on request
  initial begin : rsp_ready_ctl
    int unsigned stall;
    stall        = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end else if (stall == 0 && $urandom_range(0, 99) < 20) begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        stall--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // Compare each response transfer with the oldest expectation
  always @(posedge clk) begin : rsp_check
    alloc_rsp_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_rsps.size() == 0) begin
        error_count++;
        $display("%0t: response with none expected: found %0h block %0h read %0h status %0h",
                 $time, rsp_ch.found, rsp_ch.free_block, rsp_ch.read_value, rsp_ch.status);
      end else begin
        want = expected_rsps.pop_front();
        compare_field("found", want.found, rsp_ch.found);
        compare_field("free_block", want.free_blk, rsp_ch.free_block);
        compare_field("read_value", want.rd_val, rsp_ch.read_value);
        compare_field("status", want.status, rsp_ch.status);
      end
    end
  end

  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : main_seq
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    req_ch.valid        = 1'b0;
    req_ch.req_type     = fbba_pkg::REQ_FIND;
    req_ch.block_number = '0;
    req_ch.byte_index   = '0;
    req_ch.byte_value   = '0;
    error_count         = 0;
    idle_on             = 1'b1;
    hold_cycles         = 0;
    lim_shadow          = fbba_pkg::LIM_W'(fbba_pkg::MAP_BYTES);
    foreach (bitmap_shadow[i]) bitmap_shadow[i] = '0;
    foreach (written_shadow[i]) written_shadow[i] = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_map();
    test_directed_edges();
    test_limit_edges();
    test_random_traffic();
    test_output_backpressure();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_rsps.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
